/* rtl/core/stq_pkg.sv */
// Shared types and constants for the sorted timer queue.
package stq_pkg;
  localparam int unsigned KIND_SCHED = 0;
  localparam int unsigned KIND_POLL  = 1;

  typedef struct packed {
    logic        kind;
    logic [3:0]  timer_id;
    logic [31:0] expiry_time;
    logic        uses_handler;
    logic [31:0] now_time;
  } cmd_t;
endpackage

/* rtl/core/stq_front.sv */
// Input stage: accepts items and places them in a short command queue.
module stq_front
  import stq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic q_valid,
  input  logic q_ready,
  output cmd_t q_cmd
);
  cmd_t       mem_r [2];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_cmd;
    end
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* rtl/core/stq_back.sv */
// Execution stage: keeps the timer slots and the sorted list, runs schedules and polls.
module stq_back
  import stq_pkg::*;
#(
  parameter int SLOTS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        o_fired,
  output logic [3:0]  o_slot,
  output logic        o_mode,
  output logic [31:0] o_time,
  output logic        o_last
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_FIND = 5'b00010, S_INS = 5'b00100,
    S_POLL = 5'b01000, S_OUT  = 5'b10000
  } state_t;

  state_t              state_r;
  logic [TIME_BITS-1:0] time_r [SLOTS];
  logic                mode_r [SLOTS];
  logic [IW-1:0]       ord_r  [SLOTS];
  logic [CW-1:0]       cnt_r, pos_r;
  cmd_t                cmd_r;
  logic                shift_r, found_r, any_r;
  logic                ov_r, of_r, om_r, ol_r;
  logic [3:0]          os_r;
  logic [31:0]         ot_r;
  logic [IW-1:0]       id;
  logic [TIME_BITS-1:0] t_new, now, head_t;
  logic [IW-1:0]       head;
  logic                id_ok;

  assign id      = IW'(cmd_r.timer_id);
  assign id_ok   = ({28'd0, cmd_r.timer_id} < 32'(SLOTS));
  assign t_new   = TIME_BITS'(cmd_r.expiry_time);
  assign now     = TIME_BITS'(cmd_r.now_time);
  assign head    = ord_r[0];
  assign head_t  = time_r[head];
  assign q_ready = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign o_fired = of_r;
  assign o_slot  = os_r;
  assign o_mode  = om_r;
  assign o_time  = ot_r;
  assign o_last  = ol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < SLOTS; i++) time_r[i] <= '0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            cmd_r   <= q_cmd;
            pos_r   <= '0;
            shift_r <= 1'b0;
            any_r   <= 1'b0;
            state_r <= (q_cmd.kind == KIND_POLL[0]) ? S_POLL : S_FIND;
          end
        end
        S_FIND: begin
          if (!id_ok) begin
            state_r <= S_IDLE;
          end else if (time_r[id] == '0 || pos_r >= cnt_r) begin
            if (shift_r) cnt_r <= cnt_r - CW'(1);
            mode_r[id] <= cmd_r.uses_handler;
            time_r[id] <= t_new;
            pos_r      <= '0;
            found_r    <= 1'b0;
            state_r    <= (t_new != '0) ? S_INS : S_IDLE;
          end else begin
            if (shift_r || ord_r[pos_r[IW-1:0]] == id) begin
              shift_r <= 1'b1;
              if (32'(pos_r) + 1 < 32'(cnt_r))
                ord_r[pos_r[IW-1:0]] <= ord_r[IW'(32'(pos_r) + 1)];
            end
            pos_r <= pos_r + CW'(1);
          end
        end
        S_INS: begin
          if (cnt_r >= CW'(SLOTS)) begin
            state_r <= S_IDLE;
          end else if (pos_r == cnt_r) begin
            ord_r[pos_r[IW-1:0]] <= found_r ? ord_r[IW'(32'(pos_r) - 1)] : id;
            if (found_r) begin
              pos_r <= pos_r - CW'(1);
            end else begin
              cnt_r   <= cnt_r + CW'(1);
              state_r <= S_IDLE;
            end
          end else if (found_r) begin
            if (pos_r == '0 || t_new >= time_r[ord_r[IW'(32'(pos_r) - 1)]]) begin
              ord_r[pos_r[IW-1:0]] <= id;
              cnt_r   <= cnt_r + CW'(1);
              state_r <= S_IDLE;
            end else begin
              ord_r[pos_r[IW-1:0]] <= ord_r[IW'(32'(pos_r) - 1)];
              pos_r <= pos_r - CW'(1);
            end
          end else if (t_new < time_r[ord_r[pos_r[IW-1:0]]]) begin
            found_r <= 1'b1;
            pos_r   <= cnt_r;
          end else begin
            pos_r <= pos_r + CW'(1);
          end
        end
        S_POLL: begin
          if (!ov_r || out_ready) begin
            if (cnt_r != '0 && now >= head_t) begin
              pos_r   <= '0;
              os_r    <= 4'(head);
              om_r    <= mode_r[head];
              ot_r    <= 32'(head_t);
              time_r[head] <= '0;
              cnt_r   <= cnt_r - CW'(1);
              state_r <= S_OUT;
            end else if (!any_r) begin
              ov_r <= 1'b1; of_r <= 1'b0; os_r <= '0; om_r <= 1'b0;
              ot_r <= '0; ol_r <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          if (32'(pos_r) + 1 < 32'(cnt_r) + 1) begin
            ord_r[pos_r[IW-1:0]] <= ord_r[IW'(32'(pos_r) + 1)];
            pos_r <= pos_r + CW'(1);
          end else begin
            ov_r  <= 1'b1;
            of_r  <= 1'b1;
            any_r <= 1'b1;
            ol_r  <= (cnt_r == '0) || (now < time_r[ord_r[0]]);
            state_r <= S_POLL;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CW'(SLOTS))
    else $error("count above slots");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(o_slot) && $stable(o_last))
    else $error("result changed while stalled");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n) q_ready |-> !out_valid)
    else $error("accepted with result pending");
`endif
endmodule

/* rtl/core/sorted_timer_callout_queue.sv */
// Top level of the sorted timer queue.
// Channel | Dir | tdata (low bit up)                                   | tuser
// in_     | in  | timer_id, expiry_time, uses_handler, now_time, pad   | kind
// out_    | out | fired_slot, fired_uses_handler, fired_time, pad     | fired; tlast = last
// A schedule makes two walks of the list: one to unlink the slot, one to place it.
// A poll shifts the list after each fired slot and holds while a result waits for
// out_tready; the next item waits for the last result.
// Reset clears all slot times at once; no clearing pass is needed.
// A two-item queue lets the input side run ahead while the list is busy.
module sorted_timer_callout_queue
  import stq_pkg::*;
#(
  parameter int SLOTS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // timer_id, expiry_time, uses_handler, now_time
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // fired_slot, fired_uses_handler, fired_time
  output logic        out_tuser,  // fired
  output logic        out_tlast
);
  cmd_t        in_cmd, q_cmd;
  logic        q_valid, q_ready;
  logic [3:0]  o_slot;
  logic        o_mode;
  logic [31:0] o_time;

  assign in_cmd.kind         = in_tuser;
  assign in_cmd.timer_id     = in_tdata[3:0];
  assign in_cmd.expiry_time  = in_tdata[35:4];
  assign in_cmd.uses_handler = in_tdata[36];
  assign in_cmd.now_time     = in_tdata[68:37];
  assign out_tdata           = {3'd0, o_time, o_mode, o_slot};

  stq_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  stq_back #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd,
    .out_valid(out_tvalid), .out_ready(out_tready), .o_fired(out_tuser),
    .o_slot, .o_mode, .o_time, .o_last(out_tlast)
  );
endmodule
